>>> design/turn_order_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// turn order priority queue assertion macros
// concurrent assertion wrappers shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef TURN_ORDER_PRIORITY_QUEUE_ASSERT_SVH
`define TURN_ORDER_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TPQ_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TPQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_pkg
// shared sizes, codes and record types of the turn order priority queue
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int TIME_W      = 32;
    localparam int ACTOR_W     = 16;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_ADVANCE = 2'd1,
        FN_REMOVE  = 2'd2,
        FN_RESET   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0]  sched_time;
        logic [ACTOR_W-1:0] actor_id;
        logic               is_player;
    } entry_t;

    typedef struct packed {
        func_t              func;
        logic [ACTOR_W-1:0] actor_id;
        logic               is_player;
        logic [TIME_W-1:0]  time_value;
    } op_t;

    typedef struct packed {
        status_t                status;
        logic [ACTOR_W-1:0]     head_actor;
        logic [TIME_W-1:0]      head_time;
        logic                   head_is_player;
        logic                   queue_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

endpackage

>>> design/turn_order_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_order_priority_queue
// bounded min-priority queue of actors keyed by next action time
// ----------------------------------------------------------------------------
// One operation is taken per input transfer and gives exactly one result
// transfer with the head entry, the entry count and a status. Entries sit in
// a single-read-port table, and every operation ends with a sweep of the
// table through one compare unit to find the new head, one entry per cycle.
// An insert or an advance is followed by the head sweep alone, reset all
// times fills the table first, and remove runs a sweep to find the actor,
// a move of the last entry into its slot, then the head sweep. The input
// side is not ready while an operation runs; a finished result waits in the
// output register so the next operation can start before it is taken.
// ----------------------------------------------------------------------------
`include "turn_order_priority_queue_assert.svh"

module turn_order_priority_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // actor_id[15:0], is_player[16], time_value[48:17], zero fill
    input  logic [tpq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // head_actor[15:0], head_time[47:16], head_is_player[48],
    // queue_empty[49], entry_count[56:50], zero fill
    output logic [tpq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [1:0]                        m_axis_tuser
);
    import tpq_pkg::*;

    op_t     in_op;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    // func, actor id, player flag, time value from the msb down
    assign in_op = {s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16], s_axis_tdata[48:17]};

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (in_op),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output slot frees up in the same cycle its transfer completes
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'b0, out_reg.entry_count, out_reg.queue_empty,
                            out_reg.head_is_player, out_reg.head_time, out_reg.head_actor};

    `TPQ_ASSERT_IMPLY(a_empty_head_zero, clk, rst_n,
        out_valid_reg && out_reg.queue_empty,
        out_reg.head_actor == '0 && out_reg.head_time == '0 && !out_reg.head_is_player,
        "empty queue reports a nonzero head")
    `TPQ_ASSERT_IMPLY(a_empty_status, clk, rst_n,
        out_valid_reg && out_reg.status == ST_EMPTY,
        out_reg.queue_empty,
        "empty status on a queue that holds entries")
    `TPQ_ASSERT_IMPLY(a_full_status, clk, rst_n,
        out_valid_reg && out_reg.status == ST_FULL,
        !out_reg.queue_empty,
        "full status on an empty queue")
    `TPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_axis_tvalid && s_axis_tready,
        !s_axis_tready,
        "input taken again while an operation is running")

endmodule

>>> design/tpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tpq_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_order
// service order compare: earlier time, then player, then lower actor id
// ----------------------------------------------------------------------------
module tpq_order (
    input  tpq_pkg::entry_t cand,
    input  tpq_pkg::entry_t best,
    output logic            cand_first
);
    import tpq_pkg::*;

    always_comb
    begin
        priority if (cand.sched_time != best.sched_time)
        begin
            cand_first = cand.sched_time < best.sched_time;
        end
        else if (cand.is_player != best.is_player)
        begin
            cand_first = cand.is_player;
        end
        else
        begin
            cand_first = cand.actor_id < best.actor_id;
        end
    end

endmodule

>>> design/tpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpq_ctrl
// operation sequencer: entry table sweeps through one compare unit
// ----------------------------------------------------------------------------
module tpq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tpq_pkg::op_t     in_op,
    output logic             res_valid,
    input  logic             res_ready,
    output tpq_pkg::result_t res
);
    import tpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EXEC    = 8'b0000_0010,
        S_FILL    = 8'b0000_0100,
        S_FIND    = 8'b0000_1000,
        S_MOVE_RD = 8'b0001_0000,
        S_MOVE_WR = 8'b0010_0000,
        S_SCAN    = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    status_t           status_reg, status_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              best_found_reg, best_found_next;
    entry_t            best_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    // ram side
    logic              time_we;
    logic              id_we;
    logic [IDX_W-1:0]  waddr;
    entry_t            wr_entry;
    logic [IDX_W-1:0]  raddr;
    entry_t            rd_entry;
    logic [TIME_W-1:0] time_rdata;
    logic [ACTOR_W:0]  id_rdata;

    logic              cand_before;
    logic              scan_more;
    logic              scan_done;
    logic              key_match;
    logic              take;
    logic [CNT_W-1:0]  count_dec;
    logic [TIME_W:0]   adv_sum;
    logic [TIME_W-1:0] adv_time;

    tpq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CAPACITY)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (waddr),
        .wdata (wr_entry.sched_time),
        .raddr (raddr),
        .rdata (time_rdata)
    );

    tpq_ram #(
        .WIDTH (ACTOR_W + 1),
        .DEPTH (CAPACITY)
    ) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (waddr),
        .wdata ({wr_entry.is_player, wr_entry.actor_id}),
        .raddr (raddr),
        .rdata (id_rdata)
    );

    // time, actor id, player flag from the msb down
    assign rd_entry = {time_rdata, id_rdata[ACTOR_W-1:0], id_rdata[ACTOR_W]};

    tpq_order u_order (
        .cand       (rd_entry),
        .best       (best_reg),
        .cand_first (cand_before)
    );

    assign count_dec = count_reg - CNT_W'(1);
    assign scan_more = scan_idx_reg < count_reg;
    assign scan_done = !scan_more && !rd_vld_reg;
    assign key_match = (state_reg == S_FIND) ? (rd_entry.actor_id == op_reg.actor_id) : 1'b1;
    assign take      = rd_vld_reg && key_match && (!best_found_reg || cand_before);
    assign raddr     = (state_reg == S_MOVE_RD) ? count_dec[IDX_W-1:0]
                                                : scan_idx_reg[IDX_W-1:0];

    // saturating advance of the current head time
    assign adv_sum  = {1'b0, best_reg.sched_time} + {1'b0, op_reg.time_value};
    assign adv_time = adv_sum[TIME_W] ? TIME_MAX : adv_sum[TIME_W-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);

    always_comb
    begin
        res.status         = status_reg;
        res.queue_empty    = (count_reg == '0);
        res.entry_count    = COUNT_OUT_W'(count_reg);
        res.head_actor     = res.queue_empty ? '0 : best_reg.actor_id;
        res.head_time      = res.queue_empty ? '0 : best_reg.sched_time;
        res.head_is_player = res.queue_empty ? 1'b0 : best_reg.is_player;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = rd_vld_reg;
        best_found_next = best_found_reg;
        time_we         = 1'b0;
        id_we           = 1'b0;
        waddr           = count_reg[IDX_W-1:0];
        wr_entry.sched_time = op_reg.time_value;
        wr_entry.actor_id   = op_reg.actor_id;
        wr_entry.is_player  = op_reg.is_player;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next     = ST_OK;
                scan_idx_next   = '0;
                rd_vld_next     = 1'b0;
                best_found_next = 1'b0;
                state_next      = S_SCAN;
                unique case (op_reg.func)
                    FN_INSERT:
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            time_we    = 1'b1;
                            id_we      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_ADVANCE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            // head index is still held from the last sweep
                            waddr               = best_idx_reg;
                            wr_entry.sched_time = adv_time;
                            time_we             = 1'b1;
                        end
                    end
                    FN_REMOVE:
                    begin
                        state_next = S_FIND;
                    end
                    FN_RESET:
                    begin
                        state_next = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_SCAN;
                    end
                endcase
            end

            S_FILL:
            begin
                if (scan_more)
                begin
                    waddr         = scan_idx_reg[IDX_W-1:0];
                    time_we       = 1'b1;
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_FIND, S_SCAN:
            begin
                if (scan_more)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    rd_vld_next   = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                end
                if (take)
                begin
                    best_found_next = 1'b1;
                end
                if (scan_done)
                begin
                    if (state_reg == S_SCAN)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (best_found_reg)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        status_next     = ST_NOT_FOUND;
                        scan_idx_next   = '0;
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_MOVE_RD:
            begin
                state_next = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // last entry fills the hole left by the removed one
                waddr           = best_idx_reg;
                wr_entry        = rd_entry;
                time_we         = 1'b1;
                id_we           = 1'b1;
                count_next      = count_dec;
                scan_idx_next   = '0;
                rd_vld_next     = 1'b0;
                best_found_next = 1'b0;
                state_next      = S_SCAN;
            end

            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= ST_OK;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            scan_idx_reg   <= scan_idx_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if (take)
        begin
            best_reg     <= rd_entry;
            best_idx_reg <= rd_idx_reg;
        end
    end

endmodule

>>> tb/tb_turn_order_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turn_order_priority_queue
// self-checking bench for the turn order priority queue: a queue-fed driver
// sends insert, advance, remove and reset operations with random gaps, a
// monitor with random back-pressure compares every result field against an
// in-bench scheduler model that is updated at each accepted operation
// ----------------------------------------------------------------------------
module tb_turn_order_priority_queue;

    import tpq_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_OPS   = 50;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        op_t op;
        bit  wait_drain;
    } stim_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    // scheduler model state
    logic [TIME_W-1:0]  sched_time   [CAPACITY];
    logic [ACTOR_W-1:0] sched_actor  [CAPACITY];
    logic               sched_player [CAPACITY];
    int                 sched_count = 0;

    stim_t        op_backlog[$];
    result_t      due_results[$];
    logic [15:0]  roster_ids[$];
    stim_t        cur_stim;
    int           ops_total = 0;
    int           ops_taken = 0;
    int           fail_cnt = 0;
    int           send_gap = 0;
    int           send_calm = 0;
    int           recv_stall = 0;
    int           recv_calm = 0;
    int           idle_cycles = 0;
    bit           send_live;
    bit           take_now;
    bit           quiet_tail = 1'b0;

    turn_order_priority_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // service order: earlier time, then player, then lower id
    function automatic bit served_first(int a, int b);
        if (sched_time[a] != sched_time[b])
            return sched_time[a] < sched_time[b];
        if (sched_player[a] != sched_player[b])
            return sched_player[a];
        return sched_actor[a] < sched_actor[b];
    endfunction

    function automatic int head_slot();
        int best;
        best = 0;
        for (int i = 1; i < sched_count; i++)
            if (served_first(i, best))
                best = i;
        return best;
    endfunction

    function automatic result_t apply_turn_op(op_t op);
        result_t r;
        int h;
        int k;
        bit found;
        logic [TIME_W:0] sum;
        r = '0;
        r.status = ST_OK;
        case (op.func)
            FN_INSERT:
            begin
                if (sched_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    sched_time[sched_count]   = op.time_value;
                    sched_actor[sched_count]  = op.actor_id;
                    sched_player[sched_count] = op.is_player;
                    sched_count++;
                end
            end
            FN_ADVANCE:
            begin
                if (sched_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    h = head_slot();
                    sum = {1'b0, sched_time[h]} + {1'b0, op.time_value};
                    sched_time[h] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                end
            end
            FN_REMOVE:
            begin
                found = 1'b0;
                k = 0;
                for (int i = 0; i < sched_count; i++)
                begin
                    if (sched_actor[i] == op.actor_id)
                    begin
                        if (!found || served_first(i, k))
                            k = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    // last entry moves into the freed slot
                    sched_time[k]   = sched_time[sched_count-1];
                    sched_actor[k]  = sched_actor[sched_count-1];
                    sched_player[k] = sched_player[sched_count-1];
                    sched_count--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            FN_RESET:
            begin
                for (int i = 0; i < sched_count; i++)
                    sched_time[i] = op.time_value;
            end
        endcase
        if (sched_count == 0)
            r.queue_empty = 1'b1;
        else
        begin
            h = head_slot();
            r.head_actor     = sched_actor[h];
            r.head_time      = sched_time[h];
            r.head_is_player = sched_player[h];
        end
        r.entry_count = COUNT_OUT_W'(sched_count);
        return r;
    endfunction

    // stimulus side keeps only the id roster to aim removes at live actors
    task automatic queue_op(input func_t f, input logic [15:0] id, input logic pl,
                            input logic [31:0] tv, input bit drain);
        stim_t s;
        s.op.func       = f;
        s.op.actor_id   = id;
        s.op.is_player  = pl;
        s.op.time_value = tv;
        s.wait_drain    = drain;
        op_backlog.insert(op_backlog.size(), s);
        if (f == FN_INSERT && roster_ids.size() < CAPACITY)
            roster_ids.insert(roster_ids.size(), id);
        if (f == FN_REMOVE)
        begin
            foreach (roster_ids[i])
            begin
                if (roster_ids[i] == id)
                begin
                    roster_ids.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 12);
            1: return TIME_MAX - $urandom_range(0, 12);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [15:0] pick_victim();
        if (roster_ids.size() > 0 && $urandom_range(0, 4) != 0)
            return roster_ids[$urandom_range(0, roster_ids.size() - 1)];
        return pick_id();
    endfunction

    task automatic random_op(input int mode, input bit drain);
        int roll;
        roll = $urandom_range(0, 99);
        // mode 0 grows, 1 shrinks, 2 churns
        if ((mode == 0 && roll < 65) || (mode == 1 && roll < 10) || (mode == 2 && roll < 35))
            queue_op(FN_INSERT, pick_id(), 1'($urandom_range(0, 1)), pick_time(), drain);
        else if ((mode == 0 && roll < 80) || (mode == 1 && roll < 30) || (mode == 2 && roll < 65))
            queue_op(FN_ADVANCE, pick_id(), 1'($urandom_range(0, 1)), pick_time(), drain);
        else if (roll < 94)
            queue_op(FN_REMOVE, pick_victim(), 1'($urandom_range(0, 1)), pick_time(), drain);
        else
            queue_op(FN_RESET, pick_id(), 1'($urandom_range(0, 1)), pick_time(), drain);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            send_live = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                due_results.insert(due_results.size(), apply_turn_op(cur_stim.op));
                ops_taken++;
                send_live = 1'b0;
                quiet_tail = (ops_total - ops_taken) < TAIL_OPS;
                if (send_calm > 0)
                    send_calm--;
                else if ($urandom_range(0, 29) == 0)
                    send_calm = $urandom_range(10, 40);
                if (!quiet_tail && send_calm == 0 && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (!send_live)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (op_backlog.size() > 0 &&
                         !(op_backlog[0].wait_drain && due_results.size() != 0))
                begin
                    cur_stim = op_backlog.pop_front();
                    send_live = 1'b1;
                    s_axis_tdata <= {7'd0, cur_stim.op.time_value, cur_stim.op.is_player,
                                     cur_stim.op.actor_id};
                    s_axis_tuser <= cur_stim.op.func;
                end
            end
            s_axis_tvalid <= send_live;
        end
    end

    task automatic compare_field(input string fname, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            fail_cnt++;
            if (fail_cnt <= MAX_PRINTS)
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, fname, want_v, got_v);
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_PRINTS)
                        $display("%0t: result with nothing expected, expected none actual %h/%h",
                                 $time, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    result_t want;
                    want = due_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                    compare_field("head_actor", 32'(want.head_actor),
                                  32'(m_axis_tdata[15:0]));
                    compare_field("head_time", want.head_time, m_axis_tdata[47:16]);
                    compare_field("head_is_player", 32'(want.head_is_player),
                                  32'(m_axis_tdata[48]));
                    compare_field("queue_empty", 32'(want.queue_empty),
                                  32'(m_axis_tdata[49]));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(m_axis_tdata[56:50]));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                take_now = 1'b0;
            end
            else
            begin
                take_now = 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 199) == 0)
                    recv_calm = $urandom_range(50, 300);
                else if (!quiet_tail && $urandom_range(0, 19) == 0)
                    recv_stall = $urandom_range(1, 17);
            end
            m_axis_tready <= take_now;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int made;
        int mode;
        int len;
        int episode;

        // empty queue corner cases
        queue_op(FN_ADVANCE, 16'h0001, 1'b0, 32'd5, 1'b0);
        queue_op(FN_REMOVE, 16'h0001, 1'b0, 32'd0, 1'b0);
        queue_op(FN_RESET, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b0);
        // field extremes and tie breaks at equal time
        queue_op(FN_INSERT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        queue_op(FN_INSERT, 16'h0000, 1'b0, 32'h0000_0000, 1'b0);
        queue_op(FN_INSERT, 16'h0005, 1'b1, 32'h0000_0000, 1'b0);
        queue_op(FN_INSERT, 16'h0003, 1'b1, 32'h0000_0000, 1'b0);
        queue_op(FN_INSERT, 16'h0003, 1'b1, 32'h0000_0000, 1'b0);
        queue_op(FN_ADVANCE, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b0);
        queue_op(FN_INSERT, 16'hAAAA, 1'b0, 32'h5555_5555, 1'b0);
        queue_op(FN_INSERT, 16'h5555, 1'b1, 32'hAAAA_AAAA, 1'b0);
        // saturating advance
        queue_op(FN_RESET, 16'h0000, 1'b0, 32'h8000_0000, 1'b0);
        queue_op(FN_ADVANCE, 16'h0000, 1'b0, 32'h9000_0000, 1'b0);
        queue_op(FN_ADVANCE, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b0);
        // duplicate ids go in service order, absent id is refused
        queue_op(FN_RESET, 16'h0000, 1'b0, 32'h0000_0010, 1'b0);
        queue_op(FN_ADVANCE, 16'h0000, 1'b0, 32'h0000_0001, 1'b0);
        queue_op(FN_REMOVE, 16'h0003, 1'b0, 32'h0000_0000, 1'b0);
        // sender holds this one until every earlier result is back
        queue_op(FN_REMOVE, 16'h1234, 1'b0, 32'h0000_0000, 1'b1);
        queue_op(FN_REMOVE, 16'hFFFF, 1'b0, 32'h0000_0000, 1'b0);
        queue_op(FN_RESET, 16'h0000, 1'b0, 32'h0000_0000, 1'b0);

        made = 0;
        episode = 0;
        while (made < 450)
        begin
            if (episode == 1 || $urandom_range(0, 9) == 0)
            begin
                // fill up, then push against the full queue
                len = CAPACITY - roster_ids.size() + $urandom_range(2, 4);
                repeat (len)
                    queue_op(FN_INSERT, pick_id(), 1'($urandom_range(0, 1)), pick_time(), 1'b0);
                made += len;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len = $urandom_range(10, 40);
                for (int i = 0; i < len; i++)
                    random_op(mode, episode == 4 && i == 0);
                made += len;
            end
            episode++;
        end

        ops_total = op_backlog.size();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (ops_taken != ops_total || due_results.size() != 0);
        repeat (200) @(posedge clk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
